>>> src/pool_slot_handle_lookup_top_macros.svh
// Assertion macros shared by the pool slot handle lookup modules.
// No dependencies; included by the controller and the datapath.
`ifndef POOL_SLOT_HANDLE_LOOKUP_TOP_MACROS_SVH
`define POOL_SLOT_HANDLE_LOOKUP_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSH_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSH_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/psh_pkg.sv
// Shared types and constants of the pool slot handle lookup block.
// No dependencies; imported by the controller, the datapath and the top level.
package psh_pkg;

	localparam int FREE_BIT = 7;
	localparam logic [7:0] FREE_FLAG = 8'h80;
	localparam logic [14:0] SLOT_LIMIT = 15'd16384;
	localparam logic [15:0] MIN_ITEM = 16'h0040;

	// Configuration register indexes.
	localparam logic [1:0] CFG_POOL_BASE = 2'd0;
	localparam logic [1:0] CFG_ITEM_SIZE = 2'd1;
	localparam logic [1:0] CFG_POOL_SLOTS = 2'd2;
	localparam logic [1:0] CFG_MAX_ITEM = 2'd3;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_ADDR = 2'd1,
		MODE_INDEX = 2'd2
	} mode_t;

	typedef struct packed {
		logic load;
		logic res_zero;
		logic rd_idx;
		logic wr_flag;
		logic div_start;
		logic rd_quot;
		logic div_look;
		logic idx_sum;
		logic out_load;
		logic clr_step;
		logic rc_start;
		logic rc_step;
	} dp_cmd_t;

	typedef struct packed {
		mode_t mode;
		logic idx_mem;
		logic idx_live;
		logic addr_ok;
		logic div_done;
		logic div_hit;
		logic rc_pend;
		logic rc_done;
		logic sweep_last;
		logic cfg_wr;
	} dp_stat_t;

endpackage

>>> src/pool_slot_handle_lookup_top.sv
// Channel   Handshake              Payload
// in        in_valid / in_ready    mode, address, slot_index, flag_byte
// out       out_valid / out_ready  handle, object_address, pool_valid, used_count
// cfg       cfg_we                 cfg_index, cfg_data
//
// A flag write or an index lookup goes from dispatch to finish through at most one working state;
// an address lookup that passes the pool checks waits for the one-bit-per-cycle divider.
// After reset the flag table is cleared one slot a cycle, with in_ready low until every slot is free.
// A slot count write recounts the used slots one per cycle, over min(pool_slots, MAX_SLOTS) slots.
// A finished result waits in the output register while the next item is accepted.
//
// Top level of the pool slot handle lookup block.
// Depends on psh_pkg, psh_ctrl and psh_dp.
module pool_slot_handle_lookup_top #(
	parameter int MAX_SLOTS = 16384
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] mode,
	input logic [31:0] address,
	input logic [13:0] slot_index,
	input logic [7:0] flag_byte,
	output logic out_valid,
	input logic out_ready,
	output logic [21:0] handle,
	output logic [31:0] object_address,
	output logic pool_valid,
	output logic [14:0] used_count
);

	import psh_pkg::*;

	dp_cmd_t cmd;
	dp_stat_t stat;

	psh_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat(stat),
		.cmd(cmd)
	);

	psh_dp #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mode(mode),
		.address(address),
		.slot_index(slot_index),
		.flag_byte(flag_byte),
		.cmd(cmd),
		.stat(stat),
		.handle(handle),
		.object_address(object_address),
		.pool_valid(pool_valid),
		.used_count(used_count)
	);

endmodule

>>> src/psh_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies; holds the slot flag table.
module psh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> src/psh_div.sv
// Restoring divider, one quotient bit per cycle, 32-bit dividend by 16-bit divisor.
// No dependencies; used by the datapath for address to slot conversion.
module psh_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [31:0] dividend,
	input logic [15:0] divisor,
	output logic [31:0] quotient,
	output logic [15:0] remainder,
	output logic done
);

	localparam int DW = 32;
	localparam int CNTW = $clog2(DW);

	logic busy_q;
	logic done_q;
	logic [CNTW-1:0] cnt_q;
	logic [DW-1:0] quo_q;
	logic [15:0] rem_q;
	logic [16:0] rem_sh;
	logic [16:0] rem_diff;
	logic take;

	assign rem_sh = {rem_q, quo_q[DW-1]};
	assign rem_diff = rem_sh - {1'b0, divisor};
	assign take = rem_sh >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend shifts out at the top while quotient bits shift in at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], take};
			rem_q <= take ? rem_diff[15:0] : rem_sh[15:0];
		end
	end

	assign quotient = quo_q;
	assign remainder = rem_q;
	assign done = done_q;

endmodule

>>> src/psh_dp.sv
// Datapath: configuration registers, flag table, divider, multiplier and result registers.
// Depends on psh_pkg, psh_ram, psh_div and the assertion macro header.
`include "pool_slot_handle_lookup_top_macros.svh"

module psh_dp #(
	parameter int MAX_SLOTS = 16384
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data,
	input logic [1:0] mode,
	input logic [31:0] address,
	input logic [13:0] slot_index,
	input logic [7:0] flag_byte,
	input psh_pkg::dp_cmd_t cmd,
	output psh_pkg::dp_stat_t stat,
	output logic [21:0] handle,
	output logic [31:0] object_address,
	output logic pool_valid,
	output logic [14:0] used_count
);

	import psh_pkg::*;

	localparam int AW = $clog2(MAX_SLOTS);
	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam int PW = (CW > 15) ? CW : 15;

	function automatic logic [21:0] make_handle(input logic [13:0] slot, input logic [7:0] f);
		return f[FREE_BIT] ? 22'd0 : {slot, f};
	endfunction

	// Configuration.
	logic [31:0] pool_base_q;
	logic [15:0] item_size_q;
	logic [14:0] pool_slots_q;
	logic [15:0] max_item_q;
	logic rc_req_q;

	// Item payload.
	logic [1:0] mode_q;
	logic [31:0] addr_q;
	logic [13:0] idx_q;
	logic [7:0] flag_q;

	// Sweep and count.
	logic [CW-1:0] sweep_q;
	logic rd_vld_s1;
	logic [14:0] used_total_q;

	// Working and output results.
	logic [29:0] prod_q;
	logic [21:0] hdl_q;
	logic [31:0] obj_q;
	logic [21:0] handle_q;
	logic [31:0] obj_out_q;
	logic pool_valid_q;
	logic [14:0] used_count_q;

	logic [PW-1:0] slots_w;
	logic [PW-1:0] max_w;
	logic [PW-1:0] idx_w;
	logic [CW-1:0] span;
	logic pool_ok;
	logic idx_mem_w;
	logic idx_live_w;
	logic was_used;
	logic now_used;

	logic [AW-1:0] sweep_addr;
	logic [AW-1:0] idx_addr;
	logic [AW-1:0] quot_addr;
	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0] mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [7:0] rd_data;

	logic [31:0] div_quot;
	logic [15:0] div_rem;
	logic div_done;

	assign slots_w = PW'(pool_slots_q);
	assign max_w = PW'(MAX_SLOTS);
	assign idx_w = PW'(idx_q);
	assign span = (slots_w < max_w) ? CW'(slots_w) : CW'(max_w);

	assign pool_ok = (pool_base_q != '0) && (pool_slots_q != '0) &&
		(pool_slots_q <= SLOT_LIMIT) && (slots_w <= max_w) &&
		(item_size_q >= MIN_ITEM) && (item_size_q <= max_item_q);
	assign idx_mem_w = idx_w < max_w;
	assign idx_live_w = idx_mem_w && (idx_w < slots_w);
	assign was_used = !rd_data[FREE_BIT];
	assign now_used = !flag_q[FREE_BIT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q <= '0;
			item_size_q <= 16'd64;
			pool_slots_q <= '0;
			max_item_q <= 16'hFFFF;
			rc_req_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_POOL_BASE: pool_base_q <= cfg_data;
					CFG_ITEM_SIZE: item_size_q <= cfg_data[15:0];
					CFG_POOL_SLOTS: pool_slots_q <= cfg_data[14:0];
					CFG_MAX_ITEM: max_item_q <= cfg_data[15:0];
				endcase
			end
			// A new slot count asks for the used count to be rebuilt.
			if (cfg_we && cfg_index == CFG_POOL_SLOTS) begin
				rc_req_q <= 1'b1;
			end else if (cmd.rc_start) begin
				rc_req_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			addr_q <= address;
			idx_q <= slot_index;
			flag_q <= flag_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
			rd_vld_s1 <= 1'b0;
			used_total_q <= '0;
		end else if (cmd.clr_step) begin
			sweep_q <= sweep_q + 1'b1;
		end else if (cmd.rc_start) begin
			sweep_q <= '0;
			rd_vld_s1 <= 1'b0;
			used_total_q <= '0;
		end else if (cmd.rc_step) begin
			if (sweep_q < span) begin
				sweep_q <= sweep_q + 1'b1;
				rd_vld_s1 <= 1'b1;
			end else begin
				rd_vld_s1 <= 1'b0;
			end
			// Flags read in the previous cycle are counted as they arrive.
			if (rd_vld_s1 && !rd_data[FREE_BIT]) begin
				used_total_q <= used_total_q + 1'b1;
			end
		end else if (cmd.wr_flag && idx_live_w && (was_used != now_used)) begin
			used_total_q <= now_used ? used_total_q + 1'b1 : used_total_q - 1'b1;
		end
	end

	assign sweep_addr = sweep_q[AW-1:0];
	assign idx_addr = idx_w[AW-1:0];
	assign quot_addr = div_quot[AW-1:0];

	assign mem_we = cmd.clr_step || cmd.wr_flag;
	assign mem_waddr = cmd.clr_step ? sweep_addr : idx_addr;
	assign mem_wdata = cmd.clr_step ? FREE_FLAG : flag_q;

	always_comb begin
		priority if (cmd.rc_step) begin
			mem_raddr = sweep_addr;
		end else if (cmd.rd_quot) begin
			mem_raddr = quot_addr;
		end else begin
			mem_raddr = idx_addr;
		end
	end

	psh_ram #(
		.WIDTH(8),
		.DEPTH(MAX_SLOTS)
	) u_flags (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(rd_data)
	);

	psh_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.dividend(addr_q - pool_base_q),
		.divisor(item_size_q),
		.quotient(div_quot),
		.remainder(div_rem),
		.done(div_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.res_zero) begin
			hdl_q <= '0;
			obj_q <= '0;
			prod_q <= {16'd0, idx_q} * {14'd0, item_size_q};
		end else if (cmd.div_look) begin
			hdl_q <= make_handle(div_quot[13:0], rd_data);
			obj_q <= addr_q;
		end else if (cmd.idx_sum) begin
			obj_q <= pool_base_q + {2'b00, prod_q};
			if (idx_live_w) begin
				hdl_q <= make_handle(idx_q, rd_data);
			end
		end
		if (cmd.out_load) begin
			handle_q <= hdl_q;
			obj_out_q <= obj_q;
			pool_valid_q <= pool_ok;
			used_count_q <= pool_ok ? used_total_q : 15'd0;
		end
	end

	assign stat.mode = mode_t'(mode_q);
	assign stat.idx_mem = idx_mem_w;
	assign stat.idx_live = idx_live_w;
	assign stat.addr_ok = pool_ok && (addr_q >= pool_base_q);
	assign stat.div_done = div_done;
	assign stat.div_hit = (div_rem == '0) && (div_quot < {17'd0, pool_slots_q});
	assign stat.rc_pend = rc_req_q;
	assign stat.rc_done = (sweep_q >= span) && !rd_vld_s1;
	assign stat.sweep_last = sweep_q == CW'(MAX_SLOTS - 1);
	assign stat.cfg_wr = cfg_we;

	assign handle = handle_q;
	assign object_address = obj_out_q;
	assign pool_valid = pool_valid_q;
	assign used_count = used_count_q;

	`PSH_ASSERT_NOW(a_div_rem_bound, clk, arst_n, div_done, div_rem < item_size_q,
		"divider remainder not below item size")
	`PSH_ASSERT_NOW(a_write_in_table, clk, arst_n, cmd.wr_flag, idx_mem_w,
		"flag write outside the table")
	`PSH_ASSERT_NEXT(a_count_when_invalid, clk, arst_n, cmd.out_load,
		pool_valid_q || used_count_q == 15'd0, "used count given for an invalid pool")

endmodule

>>> src/psh_ctrl.sv
// Controller state machine: sequences clearing, recounting and each item's steps.
// Depends on psh_pkg and the assertion macro header.
`include "pool_slot_handle_lookup_top_macros.svh"

module psh_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input psh_pkg::dp_stat_t stat,
	output psh_pkg::dp_cmd_t cmd
);

	import psh_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RC_START,
		ST_RECOUNT,
		ST_DISPATCH,
		ST_WR_OLD,
		ST_DIV_RUN,
		ST_DIV_LOOK,
		ST_IDX_SUM,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic out_valid_q;

	assign in_ready = (state_q == ST_IDLE) && !stat.rc_pend && !stat.cfg_wr;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (stat.rc_pend) begin
					state_d = ST_RC_START;
				end else if (in_valid && in_ready) begin
					cmd.load = 1'b1;
					state_d = ST_DISPATCH;
				end
			end
			ST_RC_START: begin
				cmd.rc_start = 1'b1;
				state_d = ST_RECOUNT;
			end
			ST_RECOUNT: begin
				// Another slot count write restarts the sweep from the first slot.
				if (stat.rc_pend) begin
					state_d = ST_RC_START;
				end else if (stat.rc_done) begin
					state_d = ST_IDLE;
				end else begin
					cmd.rc_step = 1'b1;
				end
			end
			ST_DISPATCH: begin
				cmd.res_zero = 1'b1;
				state_d = ST_FINISH;
				unique case (stat.mode)
					MODE_WRITE: begin
						if (stat.idx_mem) begin
							cmd.rd_idx = 1'b1;
							state_d = ST_WR_OLD;
						end
					end
					MODE_ADDR: begin
						if (stat.addr_ok) begin
							cmd.div_start = 1'b1;
							state_d = ST_DIV_RUN;
						end
					end
					MODE_INDEX: begin
						cmd.rd_idx = stat.idx_live;
						state_d = ST_IDX_SUM;
					end
					default: begin
						state_d = ST_FINISH;
					end
				endcase
			end
			ST_WR_OLD: begin
				cmd.wr_flag = 1'b1;
				state_d = ST_FINISH;
			end
			ST_DIV_RUN: begin
				if (stat.div_done) begin
					if (stat.div_hit) begin
						cmd.rd_quot = 1'b1;
						state_d = ST_DIV_LOOK;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_DIV_LOOK: begin
				cmd.div_look = 1'b1;
				state_d = ST_FINISH;
			end
			ST_IDX_SUM: begin
				cmd.idx_sum = 1'b1;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				// The output register takes the result once the previous one is gone.
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`PSH_ASSERT_NEXT(a_accept_dispatch, clk, arst_n, in_valid && in_ready,
		state_q == ST_DISPATCH, "accepted item did not reach dispatch")
	`PSH_ASSERT_NOW(a_accept_no_recount, clk, arst_n, in_valid && in_ready,
		!stat.rc_pend, "item accepted while a recount is pending")
	`PSH_ASSERT_NOW(a_clear_no_result, clk, arst_n, state_q == ST_CLEAR,
		!out_valid_q, "result pending during the table clear")

endmodule
